// ----- rtl/min_tracking_stack_macros.svh -----
// Assertion macros shared by the min tracking stack RTL.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define MTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mts_pkg.sv -----
// Types and constants for the min tracking stack.
package mts_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_W       = 7;

  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] minimum;
    logic                     is_empty;
    logic [COUNT_W-1:0]       count;
    status_e                  status;
  } out_t;

endpackage

// ----- rtl/mts_stack_ram.sv -----
// Single-port-write, single-port-read stack memory with registered read data.
module mts_stack_ram #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [mts_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [mts_pkg::DATA_W-1:0] rdata_o
);

  logic [mts_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [mts_pkg::DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/min_tracking_stack.sv -----
// Min tracking stack: a stack of signed words that reports its current minimum.
// Results are registered: a push, a dropped push or an ignored pop shows its result in the cycle
//   after transfer; a pop that removes a value passes the pop state, then the output register.
// Throughput: one push per cycle while the output is not stalled; a pop holds the input while
//   the stack memories return the new top entries (synchronous read).
// Reset clears both depth counters; memory contents stay undefined, no clearing pass.
`include "min_tracking_stack_macros.svh"

module min_tracking_stack #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mts_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mts_pkg::out_t out_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW = $clog2(DEPTH + 1);
  localparam int unsigned CW = mts_pkg::COUNT_W;

  // Control state. The value stack and the minimum stack each live in one memory; the
  // entry on top of each is also cached in a register so that a push and the pop compare
  // need no read.
  mts_pkg::state_e state_q, state_d;
  logic [DW-1:0]   vdepth_q, vdepth_d;
  logic [DW-1:0]   mdepth_q, mdepth_d;
  logic            pop_min_q, pop_min_d;
  logic            out_valid_q, out_valid_d;

  // Payload state.
  logic signed [mts_pkg::DATA_W-1:0] top_q, top_d;
  logic signed [mts_pkg::DATA_W-1:0] min_q, min_d;
  mts_pkg::out_t                     out_q, out_d;

  // Memory ports.
  logic                       vwe, mwe;
  logic [mts_pkg::DATA_W-1:0] vrdata, mrdata;
  logic [AW-1:0]              vwaddr, mwaddr, vraddr, mraddr;

  logic in_accept;
  logic full;
  logic push_le_min;
  logic idle_empty;

  assign in_stall_o  = (state_q != mts_pkg::ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign full        = (vdepth_q == DW'(DEPTH));
  assign push_le_min = ($signed(in_data_i.value) <= min_q);
  // The cached minimum catches up with an emptied stack only when the pop finishes.
  assign idle_empty  = (mdepth_q == '0) && (state_q == mts_pkg::ST_IDLE);

  // Write at the current depth, read one below the current top: after a pop that
  // entry is the new top, and it is in the read register during the pop cycle.
  assign vwaddr = AW'(vdepth_q);
  assign mwaddr = AW'(mdepth_q);
  assign vraddr = AW'(vdepth_q - DW'(2));
  assign mraddr = AW'(mdepth_q - DW'(2));

  mts_stack_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (in_data_i.value),
    .raddr_i (vraddr),
    .rdata_o (vrdata)
  );

  mts_stack_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (mwe),
    .waddr_i (mwaddr),
    .wdata_i (in_data_i.value),
    .raddr_i (mraddr),
    .rdata_o (mrdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::ST_IDLE;
      vdepth_q    <= '0;
      mdepth_q    <= '0;
      pop_min_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= mts_pkg::INT_MAX;
    end else begin
      state_q     <= state_d;
      vdepth_q    <= vdepth_d;
      mdepth_q    <= mdepth_d;
      pop_min_q   <= pop_min_d;
      out_valid_q <= out_valid_d;
      min_q       <= min_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    vdepth_d    = vdepth_q;
    mdepth_d    = mdepth_q;
    pop_min_d   = pop_min_q;
    top_d       = top_q;
    min_d       = min_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    vwe         = 1'b0;
    mwe         = 1'b0;

    case (state_q)
      mts_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.cmd == mts_pkg::CMD_PUSH) begin
            if (full) begin
              // Drop the value, report the unchanged stack.
              out_valid_d    = 1'b1;
              out_d.minimum  = min_q;
              out_d.is_empty = (vdepth_q == '0);
              out_d.count    = CW'(vdepth_q);
              out_d.status   = mts_pkg::STATUS_PUSH_FULL;
            end else begin
              vwe      = 1'b1;
              top_d    = in_data_i.value;
              vdepth_d = vdepth_q + DW'(1);
              if (push_le_min) begin
                mwe      = 1'b1;
                mdepth_d = mdepth_q + DW'(1);
                min_d    = in_data_i.value;
              end
              out_valid_d    = 1'b1;
              out_d.minimum  = min_d;
              out_d.is_empty = 1'b0;
              out_d.count    = CW'(vdepth_d);
              out_d.status   = mts_pkg::STATUS_OK;
            end
          end else if (vdepth_q == '0) begin
            // Ignore a pop on an empty stack.
            out_valid_d    = 1'b1;
            out_d.minimum  = min_q;
            out_d.is_empty = 1'b1;
            out_d.count    = '0;
            out_d.status   = mts_pkg::STATUS_POP_EMPTY;
          end else begin
            // Drop the top now; pick up the new tops from memory next cycle.
            vdepth_d  = vdepth_q - DW'(1);
            pop_min_d = (top_q == min_q);
            if (top_q == min_q) begin
              mdepth_d = mdepth_q - DW'(1);
            end
            state_d = mts_pkg::ST_POP;
          end
        end
      end
      mts_pkg::ST_POP: begin
        top_d = vrdata;
        if (pop_min_q) begin
          min_d = (mdepth_q == '0) ? mts_pkg::INT_MAX : $signed(mrdata);
        end
        out_valid_d    = 1'b1;
        out_d.minimum  = min_d;
        out_d.is_empty = (vdepth_q == '0);
        out_d.count    = CW'(vdepth_q);
        out_d.status   = mts_pkg::STATUS_OK;
        state_d        = mts_pkg::ST_IDLE;
      end
      default: begin
        state_d = mts_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The minimum stack never outgrows the value stack.
  `MTS_ASSERT_SAME(a_min_not_deeper, 1'b1, mdepth_q <= vdepth_q, "min stack deeper than value stack")
  // Both stacks are empty together.
  `MTS_ASSERT_SAME(a_empty_together, 1'b1, (vdepth_q == '0) == (mdepth_q == '0), "stacks disagree")
  // An empty minimum stack reports the empty marker once no pop is in progress.
  `MTS_ASSERT_SAME(a_empty_min, idle_empty, min_q == mts_pkg::INT_MAX, "stale empty minimum")
  // A pending pop always finishes with a result in the next cycle.
  `MTS_ASSERT_NEXT(a_pop_result, state_q == mts_pkg::ST_POP, out_valid_q, "pop produced no result")
  // No transfer is taken while a pop waits for memory.
  `MTS_ASSERT_SAME(a_pop_blocks, state_q == mts_pkg::ST_POP, in_stall_o, "input taken during pop")

endmodule

// ----- dv/min_stack_monitor.sv -----
// Monitor for the min tracking stack: tracks stack contents, predicts each report and checks it.
`timescale 1ns / 1ps

module min_stack_monitor #(
  parameter int unsigned DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  mts_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  mts_pkg::out_t out_data_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_o
);
  localparam int unsigned DATA_W  = mts_pkg::DATA_W;
  localparam int unsigned COUNT_W = mts_pkg::COUNT_W;

  logic signed [DATA_W-1:0] stored_values [DEPTH];
  logic signed [DATA_W-1:0] running_mins  [DEPTH];
  int unsigned   value_cnt;
  int unsigned   min_cnt;
  mts_pkg::out_t reports_due [$];
  int unsigned   mismatches = 0;
  int unsigned   held_reports = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = held_reports;

  function automatic logic signed [DATA_W-1:0] lowest_held();
    return (min_cnt == 0) ? mts_pkg::INT_MAX : running_mins[min_cnt-1];
  endfunction

  // Apply one push or pop to the tracked stack and return the report it should produce.
  function automatic mts_pkg::out_t apply_stack_op(mts_pkg::in_t op);
    mts_pkg::out_t    rpt;
    mts_pkg::status_e st;
    st = mts_pkg::STATUS_OK;
    if (op.cmd == mts_pkg::CMD_PUSH) begin
      if (value_cnt >= DEPTH) begin
        st = mts_pkg::STATUS_PUSH_FULL;
      end else begin
        if (op.value <= lowest_held() && min_cnt < DEPTH) begin
          running_mins[min_cnt] = op.value;
          min_cnt++;
        end
        stored_values[value_cnt] = op.value;
        value_cnt++;
      end
    end else begin
      if (value_cnt == 0 || min_cnt == 0) begin
        st = mts_pkg::STATUS_POP_EMPTY;
      end else begin
        if (stored_values[value_cnt-1] == running_mins[min_cnt-1]) min_cnt--;
        value_cnt--;
      end
    end
    rpt.minimum  = lowest_held();
    rpt.is_empty = (value_cnt == 0);
    rpt.count    = COUNT_W'(value_cnt);
    rpt.status   = st;
    return rpt;
  endfunction

  function automatic void check_report(mts_pkg::out_t seen);
    mts_pkg::out_t due;
    if (reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report: min %0d empty %0b count %0d status %0d",
                 seen.minimum, seen.is_empty, seen.count, seen.status);
      return;
    end
    due = reports_due.pop_front();
    if (seen.minimum !== due.minimum || seen.is_empty !== due.is_empty ||
        seen.count !== due.count || seen.status !== due.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report mismatch: expected min %0d empty %0b count %0d status %0d,",
                 due.minimum, due.is_empty, due.count, due.status,
                 " got min %0d empty %0b count %0d status %0d",
                 seen.minimum, seen.is_empty, seen.count, seen.status);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_cnt = 0;
      min_cnt   = 0;
      reports_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_report(out_data_i);
      if (in_valid_i && !in_stall_i) reports_due.push_back(apply_stack_op(in_data_i));
    end
    held_reports = reports_due.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// Top of the min tracking stack testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DATA_W       = mts_pkg::DATA_W;
  localparam int unsigned STACK_DEPTH  = mts_pkg::DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 1850;
  // Run the last stretch of transfers with neither side idling.
  localparam int unsigned CALM_TAIL    = 150;
  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  logic          clk_i;
  logic          rst_ni    = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  mts_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  mts_pkg::out_t out_data;
  int unsigned   mismatches;
  int unsigned   awaiting;

  // Percent chance per transfer that the sender opens a gap, and per cycle
  // that the receiver starts a stall burst. Zero turns the idling off.
  int unsigned gap_odds   = 0;
  int unsigned stall_odds = 0;

  min_tracking_stack #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  min_stack_monitor #(
    .DEPTH(STACK_DEPTH)
  ) u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatches),
    .pending_o       (awaiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run, even with every transfer
  // waiting out the longest gap and the longest stall.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver side: raise stall in bursts of random length. Update the stall
  // exactly once per edge so a burst never glitches low within a time step.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
        stall_left = $urandom_range(1, 13);
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Offer one operation and hold it until the block takes the transfer.
  // An optional gap drops valid first; otherwise valid stays high straight
  // into the next item so it is written once per edge.
  task automatic send_op(input mts_pkg::cmd_e op, input logic signed [DATA_W-1:0] operand);
    if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    in_data.cmd   <= op;
    in_data.value <= operand;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Favor the extremes and a narrow band around zero so equal minimums and
  // duplicate values show up often; the rest toggles every bit.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return mts_pkg::INT_MAX;
      1:       return INT_MIN;
      2, 3:    return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned seg_len;
    int unsigned push_pct;
    int unsigned mode;

    // Hold reset low from the start, then release it at an edge.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pass: light output stalls only.
    stall_odds = 10;
    send_op(mts_pkg::CMD_POP, 32'h0);          // pop on empty: ignore and flag
    send_op(mts_pkg::CMD_PUSH, mts_pkg::INT_MAX); // INT_MAX onto an empty stack
    send_op(mts_pkg::CMD_PUSH, mts_pkg::INT_MAX); // equal to the minimum: track it again
    send_op(mts_pkg::CMD_POP, 32'hFFFF_FFFF);
    send_op(mts_pkg::CMD_POP, 32'h0);
    send_op(mts_pkg::CMD_POP, 32'h0);          // empty again
    send_op(mts_pkg::CMD_PUSH, 32'sd10);
    send_op(mts_pkg::CMD_PUSH, 32'sd3);
    send_op(mts_pkg::CMD_PUSH, 32'sd3);        // duplicate minimum
    send_op(mts_pkg::CMD_PUSH, 32'sd7);        // above the minimum: not tracked
    send_op(mts_pkg::CMD_PUSH, INT_MIN);
    send_op(mts_pkg::CMD_PUSH, INT_MIN);
    send_op(mts_pkg::CMD_PUSH, 32'sd0);
    send_op(mts_pkg::CMD_PUSH, -32'sd1);
    repeat (9) send_op(mts_pkg::CMD_POP, 32'h5555_AAAA);  // drain fully, one pop past empty
    send_op(mts_pkg::CMD_PUSH, 32'hAAAA_5555);
    send_op(mts_pkg::CMD_POP, 32'h0);

    // Random pass: segments that fill, drain or hover, each with its own
    // idling level. Open with a fill so a full stack is reached early.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = (sent == 0) ? 1 : $urandom_range(0, 2);
      case (mode)
        0: begin
          push_pct = 50;
          seg_len  = $urandom_range(20, 120);
        end
        1: begin
          push_pct = 85;
          seg_len  = $urandom_range(90, 160);
        end
        default: begin
          push_pct = 15;
          seg_len  = $urandom_range(40, 120);
        end
      endcase
      case ($urandom_range(0, 3))
        0: begin
          gap_odds   = 0;
          stall_odds = 0;
        end
        1: begin
          gap_odds   = 10;
          stall_odds = 10;
        end
        2: begin
          gap_odds   = 35;
          stall_odds = 5;
        end
        default: begin
          gap_odds   = 5;
          stall_odds = 35;
        end
      endcase
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
          gap_odds   = 0;
          stall_odds = 0;
        end
        if ($urandom_range(1, 100) <= push_pct) send_op(mts_pkg::CMD_PUSH, pick_value());
        else send_op(mts_pkg::CMD_POP, $urandom());
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted report, then allow the pop latency to
    // pass so a stray extra report still gets caught.
    wait (awaiting == 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && awaiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
